[rtl/core/psto_pkg.sv]
// Shared types and constants for the polyphonic sine table oscillator.
// Holds the request and response payload structs, operation codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psto_pkg;

   // Sine table geometry and fixed-point formats.
   localparam int TABLE_SIZE      = 2048;
   localparam int IDX_BITS        = $clog2(TABLE_SIZE);
   localparam int PHASE_FRAC_BITS = 21;
   localparam int POS_BITS        = IDX_BITS + PHASE_FRAC_BITS;
   localparam int PHASE_BITS      = 32;
   localparam int SAMPLE_BITS     = 16;
   localparam int ROM_DEPTH       = TABLE_SIZE + 1;
   localparam int ROM_AW          = IDX_BITS + 1;
   localparam int AMP_BITS        = 16;
   localparam int GAIN_FRAC_BITS  = 14;
   localparam int VOICE_BITS      = 4;
   localparam int OP_BITS         = 2;
   localparam int CSR_IDX_BITS    = 2;

   // 20.43356 table steps per sample in Q11.21, and unity gain in Q2.14.
   localparam logic [PHASE_BITS-1:0] INC_RESET = 32'd42852281;
   localparam logic [AMP_BITS-1:0]   AMP_RESET = 16'd16384;

   localparam logic [OP_BITS-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_WR_INC = 2'd1;
   localparam logic [OP_BITS-1:0] OP_WR_AMP = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FM_ENABLE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AM_ENABLE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MONO_MODE = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]    operation;
      logic [VOICE_BITS-1:0] voice;
      logic [31:0]           write_value;
      logic signed [31:0]    fm_offset;
      logic signed [15:0]    am_offset;
   } req_type;

   typedef struct packed {
      logic [VOICE_BITS-1:0]         out_voice;
      logic signed [SAMPLE_BITS-1:0] sample;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/polyphonic_sine_table_oscillator_top.sv]
// Top level of the polyphonic sine table oscillator: voice state memories and tick sequencer.
// Depends on psto_pkg and psto_sine_rom.
//
// Usage: requests arrive on req_valid/req_ready with a req_type payload. A write request
// (increment or amplitude) is written at the accepting edge and req_ready stays high, so
// writes stream at one per cycle while no tick is in progress. A tick request reads the
// voice's phase and parameters from the state memories, then walks a sequencer through
// position add, ROM read, interpolation multiply, rounding, gain multiply and saturation.
// The sample reaches the rsp output register as the sequencer leaves its output step, and
// req_ready returns high at that same edge; no new request is taken while a tick is in
// progress. The phase write-back happens inside that walk, so the next tick of any voice
// always sees the updated phase. If the receiver stalls with a sample still held, the new
// sample waits in the sequencer until the output register frees; requests are refused
// meanwhile. Configuration writes on csr_valid/csr_ready are taken whenever not in reset.
// Reset clears the per-voice valid bits, so every voice reads back its reset phase,
// increment and amplitude at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module polyphonic_sine_table_oscillator_top #(
   parameter int NUM_VOICES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  psto_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output psto_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psto_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic                                  csr_wdata
);
   import psto_pkg::*;

   localparam int VoiceAw = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int GainW   = AMP_BITS + 1;
   localparam int YW      = SAMPLE_BITS + 1;
   localparam int Prod1W  = SAMPLE_BITS + PHASE_FRAC_BITS + 2;
   localparam int Prod2W  = YW + GainW;
   localparam int SatW    = Prod2W + 1;
   localparam logic signed [SatW-1:0] SatMax =
      SatW'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SatW-1:0] SatMin = -SatMax - SatW'(1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_POS  = 3'd1;
   localparam logic [2:0] S_ROM  = 3'd2;
   localparam logic [2:0] S_MUL1 = 3'd3;
   localparam logic [2:0] S_Y    = 3'd4;
   localparam logic [2:0] S_MUL2 = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   // Control state.
   logic [2:0]            state_ff, state_in;
   logic                  fm_enable_ff, am_enable_ff, mono_mode_ff;
   logic [NUM_VOICES-1:0] phase_vld_ff, inc_vld_ff, amp_vld_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Memories.
   logic [PHASE_BITS-1:0]          phase_mem [NUM_VOICES];
   logic [PHASE_BITS+AMP_BITS-1:0] voice_mem [NUM_VOICES];
   logic [PHASE_BITS-1:0]          phase_rd_ff;
   logic [PHASE_BITS+AMP_BITS-1:0] voice_rd_ff;
   logic                           phase_rd_vld_ff, inc_rd_vld_ff, amp_rd_vld_ff;

   // Per-item payload.
   logic [VOICE_BITS-1:0]          voice_ff;
   logic signed [31:0]             fm_ff;
   logic signed [15:0]             am_ff;
   logic [PHASE_BITS-1:0]          pos_ff, inc_ff;
   logic signed [GainW-1:0]        gain_ff;
   logic signed [SAMPLE_BITS-1:0]  t0_ff;
   logic signed [Prod1W-1:0]       prod1_ff;
   logic signed [YW-1:0]           y_ff;
   logic signed [Prod2W-1:0]       prod2_ff;
   rsp_type                        rsp_data_ff;

   // Request decode.
   logic                  req_accept, tick_accept, inc_we, amp_we;
   logic [VOICE_BITS-1:0] voice_sat, tick_voice, addr_voice;
   logic [VoiceAw-1:0]    mem_addr, phase_waddr;
   logic                  phase_we;
   logic                  out_load;

   // Datapath.
   logic [PHASE_BITS-1:0]         phase_eff, inc_eff, fm_eff, pos_sum, pos_in;
   logic [PHASE_BITS-1:0]         phase_sum, phase_next;
   logic [AMP_BITS-1:0]           amp_eff;
   logic signed [GainW-1:0]       amp_ext, am_ext, gain_in;
   logic [ROM_AW-1:0]             rom_addr_a, rom_addr_b;
   logic signed [SAMPLE_BITS-1:0] rom_a, rom_b;
   logic signed [YW-1:0]          diff;
   logic signed [PHASE_FRAC_BITS:0] frac_s;
   logic signed [Prod1W-1:0]      prod1_in, rnd_sum, rnd_q;
   logic signed [YW-1:0]          y_in;
   logic signed [Prod2W-1:0]      prod2_in;
   logic signed [SatW-1:0]        s_sum, s_q;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   assign req_ready   = (state_ff == S_IDLE) && !reset;
   assign csr_ready   = !reset;
   assign req_accept  = req_valid && req_ready;
   assign tick_accept = req_accept && (req_data.operation == OP_TICK);
   assign inc_we      = req_accept && (req_data.operation == OP_WR_INC);
   assign amp_we      = req_accept && (req_data.operation == OP_WR_AMP);

   // Out-of-range voices fold onto the last voice; mono ticks use voice zero.
   assign voice_sat  = (32'(req_data.voice) >= 32'(NUM_VOICES)) ?
                       VOICE_BITS'(NUM_VOICES - 1) : req_data.voice;
   assign tick_voice = mono_mode_ff ? '0 : voice_sat;
   assign addr_voice = (req_data.operation == OP_TICK) ? tick_voice : voice_sat;
   assign mem_addr   = VoiceAw'(addr_voice);
   assign phase_waddr = VoiceAw'(voice_ff);
   assign phase_we   = (state_ff == S_ROM);

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (tick_accept) state_in = S_POS;
         S_POS:  state_in = S_ROM;
         S_ROM:  state_in = S_MUL1;
         S_MUL1: state_in = S_Y;
         S_Y:    state_in = S_MUL2;
         S_MUL2: state_in = S_OUT;
         S_OUT:  if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fm_enable_ff <= 1'b0;
         am_enable_ff <= 1'b0;
         mono_mode_ff <= 1'b0;
         phase_vld_ff <= '0;
         inc_vld_ff   <= '0;
         amp_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FM_ENABLE: fm_enable_ff <= csr_wdata;
               CSR_AM_ENABLE: am_enable_ff <= csr_wdata;
               CSR_MONO_MODE: mono_mode_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (inc_we) inc_vld_ff[mem_addr] <= 1'b1;
         if (amp_we) amp_vld_ff[mem_addr] <= 1'b1;
         if (phase_we) phase_vld_ff[phase_waddr] <= 1'b1;
      end
   end

   // Phase memory: read at tick accept, written back once the position is known.
   always_ff @(posedge clock) begin
      if (phase_we) phase_mem[phase_waddr] <= phase_next;
      if (tick_accept) phase_rd_ff <= phase_mem[mem_addr];
   end

   // Voice parameter memory: increment in the upper field, amplitude in the lower.
   always_ff @(posedge clock) begin
      if (inc_we) voice_mem[mem_addr][PHASE_BITS+AMP_BITS-1:AMP_BITS] <= req_data.write_value;
      if (amp_we) voice_mem[mem_addr][AMP_BITS-1:0] <= req_data.write_value[AMP_BITS-1:0];
      if (tick_accept) voice_rd_ff <= voice_mem[mem_addr];
   end

   // Position and gain. Entries never written read as their reset values.
   assign phase_eff = phase_rd_vld_ff ? phase_rd_ff : '0;
   assign inc_eff   = inc_rd_vld_ff ? voice_rd_ff[PHASE_BITS+AMP_BITS-1:AMP_BITS] : INC_RESET;
   assign amp_eff   = amp_rd_vld_ff ? voice_rd_ff[AMP_BITS-1:0] : AMP_RESET;
   assign fm_eff    = fm_enable_ff ? PHASE_BITS'(fm_ff) : '0;
   // The table period is a power of two, so the wrap is a truncation of the sum.
   assign pos_sum   = phase_eff + fm_eff;
   assign pos_in    = PHASE_BITS'(pos_sum[POS_BITS-1:0]);
   assign amp_ext   = GainW'($signed(amp_eff));
   assign am_ext    = am_enable_ff ? GainW'(am_ff) : '0;
   assign gain_in   = amp_ext + am_ext;

   assign phase_sum  = pos_ff + inc_ff;
   assign phase_next = PHASE_BITS'(phase_sum[POS_BITS-1:0]);

   assign rom_addr_a = ROM_AW'(pos_ff[POS_BITS-1:PHASE_FRAC_BITS]);
   assign rom_addr_b = rom_addr_a + ROM_AW'(1);

   psto_sine_rom u_sine_rom (
      .clock     (clock),
      .rd_addr_a (rom_addr_a),
      .rd_addr_b (rom_addr_b),
      .rd_data_a (rom_a),
      .rd_data_b (rom_b)
   );

   // Interpolation between adjacent entries, rounded to nearest.
   assign diff     = YW'(rom_b) - YW'(rom_a);
   assign frac_s   = $signed({1'b0, pos_ff[PHASE_FRAC_BITS-1:0]});
   assign prod1_in = Prod1W'(diff) * Prod1W'(frac_s);
   assign rnd_sum  = prod1_ff + $signed(Prod1W'(1) << (PHASE_FRAC_BITS - 1));
   assign rnd_q    = rnd_sum >>> PHASE_FRAC_BITS;
   assign y_in     = YW'(t0_ff) + YW'(rnd_q);

   // Gain scaling, rounding and saturation.
   assign prod2_in = Prod2W'(y_ff) * Prod2W'(gain_ff);
   assign s_sum    = SatW'(prod2_ff) + $signed(SatW'(1) << (GAIN_FRAC_BITS - 1));
   assign s_q      = s_sum >>> GAIN_FRAC_BITS;
   assign sample_in = (s_q > SatMax) ? SAMPLE_BITS'(SatMax) :
                      (s_q < SatMin) ? SAMPLE_BITS'(SatMin) : SAMPLE_BITS'(s_q);

   always_ff @(posedge clock) begin
      if (tick_accept) begin
         voice_ff        <= tick_voice;
         fm_ff           <= req_data.fm_offset;
         am_ff           <= req_data.am_offset;
         phase_rd_vld_ff <= phase_vld_ff[mem_addr];
         inc_rd_vld_ff   <= inc_vld_ff[mem_addr];
         amp_rd_vld_ff   <= amp_vld_ff[mem_addr];
      end
      if (state_ff == S_POS) begin
         pos_ff  <= pos_in;
         inc_ff  <= inc_eff;
         gain_ff <= gain_in;
      end
      if (state_ff == S_MUL1) begin
         prod1_ff <= prod1_in;
         t0_ff    <= rom_a;
      end
      if (state_ff == S_Y) y_ff <= y_in;
      if (state_ff == S_MUL2) prod2_ff <= prod2_in;
      if (out_load) begin
         rsp_data_ff.out_voice <= voice_ff;
         rsp_data_ff.sample    <= sample_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/core/psto_sine_rom.sv]
// Dual-port sine ROM with registered read data, TABLE_SIZE+1 entries.
// Contents are computed at elaboration from an integer Taylor series.
// Depends on psto_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psto_sine_rom (
   input  logic                                     clock,
   input  logic [psto_pkg::ROM_AW-1:0]              rd_addr_a,
   input  logic [psto_pkg::ROM_AW-1:0]              rd_addr_b,
   output logic signed [psto_pkg::SAMPLE_BITS-1:0]  rd_data_a,
   output logic signed [psto_pkg::SAMPLE_BITS-1:0]  rd_data_b
);
   import psto_pkg::*;

   typedef logic signed [SAMPLE_BITS-1:0] rom_word_type;
   typedef rom_word_type rom_array_type [ROM_DEPTH];

   localparam longint OneQ30    = 64'sd1073741824;
   localparam longint HalfPiQ30 = 64'sd1686629713;
   localparam longint SampleMax = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

   // Angle in Q30 over the first quadrant, result in Q30.
   function automatic longint sin_q30(input longint x);
      longint x2;
      longint term;
      longint sum;
      x2   = (x * x) / OneQ30;
      term = x;
      sum  = x;
      // Each term is the previous one times -x^2 / ((2k)(2k+1)), for k from 1 to 12.
      term = -((term * x2) / OneQ30) / 64'sd6;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd20;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd42;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd72;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd110;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd156;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd210;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd272;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd342;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd420;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd506;
      sum  = sum + term;
      term = -((term * x2) / OneQ30) / 64'sd600;
      sum  = sum + term;
      if (sum < 0) sum = 0;
      if (sum > OneQ30) sum = OneQ30;
      return sum;
   endfunction

   // Quarter-wave symmetry: odd quadrants mirror the angle, the upper half negates.
   function automatic rom_word_type sine_entry(input longint i);
      longint t;
      longint quad;
      longint rem_q;
      longint s;
      longint v;
      t     = i * 4;
      quad  = t / TABLE_SIZE;
      rem_q = t % TABLE_SIZE;
      if ((quad & 1) != 0) rem_q = TABLE_SIZE - rem_q;
      s = sin_q30((HalfPiQ30 * rem_q) / TABLE_SIZE);
      v = (s * SampleMax + (OneQ30 / 2)) / OneQ30;
      if ((quad & 2) != 0) v = -v;
      return SAMPLE_BITS'(v);
   endfunction

   function automatic rom_array_type build_rom();
      rom_array_type r;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         r[i] = sine_entry(longint'(i));
      end
      return r;
   endfunction

   localparam rom_array_type SineRom = build_rom();

   rom_word_type rd_data_a_ff;
   rom_word_type rd_data_b_ff;

   always_ff @(posedge clock) begin
      rd_data_a_ff <= SineRom[rd_addr_a];
      rd_data_b_ff <= SineRom[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

[rtl/core/psto_checker.sv]
// Port-level assertions for the polyphonic sine table oscillator, bound to the top level.
// Depends on psto_pkg and polyphonic_sine_table_oscillator_top.
`timescale 1ns / 1ps
`default_nettype none

module psto_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input psto_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input psto_pkg::rsp_type rsp_data
);
   import psto_pkg::*;

   // A held sample stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // A tick occupies the sequencer, so the next request must wait.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.operation == OP_TICK |=> !req_ready)
      else $error("request taken while a tick was in progress");

   // Writes and ignored operations never block the request channel.
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.operation != OP_TICK |=> req_ready)
      else $error("non-tick request stalled the request channel");

   // A new sample appears only from the final sequencer step, when requests are refused.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a tick finishing");

endmodule

bind polyphonic_sine_table_oscillator_top psto_checker u_checker (.*);

`default_nettype wire

[test/polyphonic_sine_table_oscillator_top_test.sv]
// Self-checking testbench for polyphonic_sine_table_oscillator_top.
// Predicts every sample from its own copy of the voice state and sine table and checks
// the responses in order. Depends on psto_pkg and the oscillator RTL.
`timescale 1ns / 1ps

module polyphonic_sine_table_oscillator_top_test;
   import psto_pkg::*;

   localparam int NUM_VOICES     = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int PHASE_ITEMS    = 125;
   localparam int RANDOM_PHASES  = 8;
   localparam int BURST_ITEMS    = 24;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   localparam longint PERIOD      = longint'(TABLE_SIZE) << PHASE_FRAC_BITS;
   localparam longint FRAC_MASK   = (64'sd1 <<< PHASE_FRAC_BITS) - 1;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint SAMPLE_MAX  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic    csr_wdata;

   // Predicted oscillator state.
   logic [PHASE_BITS-1:0] voice_phase     [0:NUM_VOICES-1];
   logic [PHASE_BITS-1:0] voice_increment [0:NUM_VOICES-1];
   logic [AMP_BITS-1:0]   voice_amplitude [0:NUM_VOICES-1];
   longint                sine_values     [0:TABLE_SIZE];
   logic                  fm_on, am_on, mono_on;
   rsp_type               expected_samples [$];

   logic idle_on = 1'b1;
   int   hold_requests = 0;
   int   error_count = 0;
   int   quiet_cycles = 0;

   polyphonic_sine_table_oscillator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Taylor series for sin over 0..pi/2, Q30 in and out, truncating like integer C.
   function automatic longint sine_q30(input longint x);
      longint x2, term, sum, k;
      x2   = (x * x) / ONE_Q30;
      term = x;
      sum  = x;
      for (k = 1; k <= 12; k++) begin
         term = -((term * x2) / ONE_Q30) / ((2 * k) * (2 * k + 1));
         sum += term;
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      return sum;
   endfunction

   // One table entry built from the quarter wave.
   function automatic longint sine_entry(input int i);
      longint t, quad, rem, s, v;
      t    = longint'(i) * 4;
      quad = t / TABLE_SIZE;
      rem  = t % TABLE_SIZE;
      if ((quad & 1) != 0) rem = TABLE_SIZE - rem;
      s = sine_q30((HALF_PI_Q30 * rem) / TABLE_SIZE);
      v = (s * SAMPLE_MAX + ONE_Q30 / 2) / ONE_Q30;
      return ((quad & 2) != 0) ? -v : v;
   endfunction

   function automatic void reset_oscillator_model();
      for (int i = 0; i < NUM_VOICES; i++) begin
         voice_phase[i]     = '0;
         voice_increment[i] = INC_RESET;
         voice_amplitude[i] = AMP_RESET;
      end
      for (int i = 0; i <= TABLE_SIZE; i++) sine_values[i] = sine_entry(i);
      fm_on   = 1'b0;
      am_on   = 1'b0;
      mono_on = 1'b0;
   endfunction

   // Applies one accepted request to the predicted state and queues its sample, if any.
   function automatic void predict_oscillator(input req_type r);
      int      v;
      longint  pos, idx, frac, d, y, gain, s;
      rsp_type sample_out;
      v = int'(r.voice);
      if (v >= NUM_VOICES) v = NUM_VOICES - 1;
      case (r.operation)
         OP_WR_INC: voice_increment[v] = r.write_value;
         OP_WR_AMP: voice_amplitude[v] = r.write_value[AMP_BITS-1:0];
         OP_TICK: begin
            if (mono_on) v = 0;
            pos = longint'(voice_phase[v]);
            if (fm_on) pos += longint'($signed(r.fm_offset));
            pos = pos % PERIOD;
            if (pos < 0) pos += PERIOD;
            idx  = pos >>> PHASE_FRAC_BITS;
            frac = pos & FRAC_MASK;
            if (idx > TABLE_SIZE - 1) idx = TABLE_SIZE - 1;
            d = sine_values[idx + 1] - sine_values[idx];
            y = sine_values[idx] +
                ((d * frac + (64'sd1 <<< (PHASE_FRAC_BITS - 1))) >>> PHASE_FRAC_BITS);
            gain = longint'($signed(voice_amplitude[v]));
            if (am_on) gain += longint'($signed(r.am_offset));
            s = (y * gain + (64'sd1 <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
            if (s > SAMPLE_MAX) s = SAMPLE_MAX;
            if (s < SAMPLE_MIN) s = SAMPLE_MIN;
            voice_phase[v] = PHASE_BITS'((pos + longint'(voice_increment[v])) % PERIOD);
            sample_out.out_voice = v[VOICE_BITS-1:0];
            sample_out.sample    = s[SAMPLE_BITS-1:0];
            expected_samples = {expected_samples, sample_out};
         end
         default: ;
      endcase
   endfunction

   function automatic req_type make_request(input logic [OP_BITS-1:0] op,
                                            input logic [VOICE_BITS-1:0] voice,
                                            input logic [31:0] value,
                                            input logic [31:0] fm,
                                            input logic [15:0] am);
      req_type r;
      r.operation   = op;
      r.voice       = voice;
      r.write_value = value;
      r.fm_offset   = fm;
      r.am_offset   = am;
      return r;
   endfunction

   // Mostly ticks, with enough writes that increments and gains keep changing.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      r = make_request(OP_TICK, VOICE_BITS'($urandom_range(NUM_VOICES - 1)), $urandom,
                       $urandom, 16'($urandom));
      if (pick >= 95) begin
         r.operation = OP_UNUSED;
      end else if (pick >= 80) begin
         r.operation = OP_WR_AMP;
         if ($urandom_range(1)) r.write_value[15:0] = 16'($urandom_range(20000));
      end else if (pick >= 65) begin
         r.operation = OP_WR_INC;
         if ($urandom_range(1)) r.write_value = $urandom_range(32'h1000_0000);
      end
      return r;
   endfunction

   // Sends one request; starts and ends at a falling edge.
   task automatic send_request(input req_type r);
      int gap;
      if (idle_on && $urandom_range(99) < 8) begin
         gap = $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
      end
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_oscillator(r);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Holds off new requests until every predicted sample has arrived.
   task automatic wait_for_samples();
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic value);
      csr_index = idx;
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FM_ENABLE: fm_on   = value;
         CSR_AM_ENABLE: am_on   = value;
         CSR_MONO_MODE: mono_on = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_config(input logic fm, input logic am, input logic mono);
      wait_for_samples();
      write_csr(CSR_FM_ENABLE, fm);
      write_csr(CSR_AM_ENABLE, am);
      write_csr(CSR_MONO_MODE, mono);
   endtask

   // Every voice starts at phase zero, so the first ticks must give silence.
   task automatic test_reset_state();
      send_request(make_request(OP_TICK, 0, 0, 0, 0));
      send_request(make_request(OP_TICK, 7, 0, 0, 0));
      send_request(make_request(OP_TICK, 15, '1, '1, '1));
      send_request(make_request(OP_UNUSED, 0, 0, 0, 0));
   endtask

   task automatic test_field_extremes();
      apply_config(1'b0, 1'b0, 1'b0);
      send_request(make_request(OP_WR_INC, 15, 32'hFFFF_FFFF, 0, 0));
      send_request(make_request(OP_WR_AMP, 15, 32'h0000_8000, 0, 0));
      send_request(make_request(OP_TICK, 15, 0, 0, 0));
      send_request(make_request(OP_TICK, 15, 0, 0, 0));
      send_request(make_request(OP_WR_AMP, 1, 32'hFFFF_7FFF, 0, 0));
      send_request(make_request(OP_TICK, 1, 0, 0, 0));
      send_request(make_request(OP_WR_INC, 2, 32'h0000_0000, 0, 0));
      send_request(make_request(OP_TICK, 2, 0, 0, 0));
      send_request(make_request(OP_TICK, 2, 0, 0, 0));
      send_request(make_request(OP_UNUSED, 15, '1, '1, '1));
   endtask

   // Offsets at both ends, a position that goes negative, and gains that saturate.
   task automatic test_modulation();
      apply_config(1'b1, 1'b1, 1'b0);
      send_request(make_request(OP_TICK, 3, 0, 32'hFFFF_FFFF, 0));
      send_request(make_request(OP_TICK, 4, 0, 32'h7FFF_FFFF, 16'h7FFF));
      send_request(make_request(OP_TICK, 5, 0, 32'h8000_0000, 16'h8000));
      send_request(make_request(OP_WR_AMP, 6, 32'h0000_7FFF, 0, 0));
      send_request(make_request(OP_TICK, 6, 0, 32'h2000_0000, 16'h7FFF));
      send_request(make_request(OP_WR_AMP, 7, 32'h0000_8000, 0, 0));
      send_request(make_request(OP_TICK, 7, 0, 32'h2000_0000, 16'h8000));
   endtask

   // In mono mode ticks use voice zero, but writes still land on the addressed voice.
   task automatic test_mono_mode();
      apply_config(1'b0, 1'b0, 1'b1);
      send_request(make_request(OP_WR_INC, 9, 32'h0100_0000, 0, 0));
      send_request(make_request(OP_WR_AMP, 9, 32'h0000_2000, 0, 0));
      send_request(make_request(OP_TICK, 9, 0, 0, 0));
      send_request(make_request(OP_TICK, 12, 0, 0, 0));
   endtask

   // The receiver stops for a long stretch while ticks keep coming, so the block fills.
   task automatic test_output_backpressure();
      apply_config(1'b1, 1'b1, 1'b0);
      hold_requests = hold_requests + 1;
      for (int i = 0; i < BURST_ITEMS; i++) begin
         send_request(make_request(OP_TICK, VOICE_BITS'($urandom_range(NUM_VOICES - 1)), 0,
                                   $urandom, 16'($urandom)));
      end
      wait_for_samples();
   endtask

   task automatic test_random_traffic();
      req_type r;
      int      sent;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0)      apply_config(1'b0, 1'b0, 1'b0);
         else if (p == 1) apply_config(1'b1, 1'b1, 1'b1);
         else             apply_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                                       1'($urandom_range(1)));
         // One phase runs with no idling on either side.
         idle_on = (p != 3);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r = random_request();
            send_request(r);
            if (r.operation != OP_UNUSED) sent++;
         end
      end
      idle_on = 1'b1;
   endtask

   // Receiver: random stalls, plus the long hold-off when a test asks for one.
   initial begin : response_side
      int holds_done;
      holds_done = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done = holds_done + 1;
            rsp_ready  = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready = idle_on ? ($urandom_range(99) >= 8) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $error("unexpected sample: voice %0d, sample %0d",
                   rsp_data.out_voice, $signed(rsp_data.sample));
            error_count++;
         end else begin
            if (rsp_data.out_voice !== expected_samples[0].out_voice) begin
               $error("out_voice mismatch: expected %0d, actual %0d",
                      expected_samples[0].out_voice, rsp_data.out_voice);
               error_count++;
            end
            if (rsp_data.sample !== expected_samples[0].sample) begin
               $error("sample mismatch: expected %0d, actual %0d",
                      $signed(expected_samples[0].sample), $signed(rsp_data.sample));
               error_count++;
            end
            void'(expected_samples.pop_front());
         end
      end
   end

   // Ends the run if no handshake of any kind completes for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $error("no handshake for %0d cycles, %0d samples outstanding",
                STALL_LIMIT, expected_samples.size());
         $display("** polyphonic_sine_table_oscillator_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = 1'b0;
      reset_oscillator_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_field_extremes();
      test_modulation();
      test_mono_mode();
      test_output_backpressure();
      test_random_traffic();

      wait_for_samples();
      if (error_count == 0) begin
         $display("** polyphonic_sine_table_oscillator_top: PASSED **");
      end else begin
         $display("** polyphonic_sine_table_oscillator_top: FAILED **");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/psto_pkg.sv
rtl/core/psto_sine_rom.sv
rtl/core/polyphonic_sine_table_oscillator_top.sv
rtl/core/psto_checker.sv
test/polyphonic_sine_table_oscillator_top_test.sv
